// ----- rtl/core/yuyv_luma_nearest_downscaler_unit_macros.svh -----
// Assertion macros shared by the downscaler RTL.
// Included by files that check their own logic; empty when SYNTHESIS is set.
`ifndef YUYV_LUMA_NEAREST_DOWNSCALER_UNIT_MACROS_SVH
`define YUYV_LUMA_NEAREST_DOWNSCALER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define YDN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define YDN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define YDN_ASSERT_IMP(label, clk, rst, ante, cons)
`define YDN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/ydn_pkg.sv -----
// Shared sizes, widths, register codes and bundle types for the downscaler.
// No dependencies.
package ydn_pkg;

  localparam int MAX_SOURCE_SIZE = 4096;
  localparam int MAX_TARGET_SIZE = 512;

  localparam int SRC_W = $clog2(MAX_SOURCE_SIZE + 1);
  localparam int TGT_W = $clog2(MAX_TARGET_SIZE + 1);
  localparam int POS_W = $clog2(MAX_SOURCE_SIZE);
  localparam int DST_W = TGT_W;
  localparam int ACC_W = SRC_W + TGT_W - 1;
  localparam int CFG_W = (SRC_W > TGT_W) ? SRC_W : TGT_W;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] LUMA_BIAS = BYTE_W'(128);

  localparam logic [SRC_W-1:0] SRC_MAX = SRC_W'(MAX_SOURCE_SIZE);
  localparam logic [TGT_W-1:0] TGT_MAX = TGT_W'(MAX_TARGET_SIZE);

  localparam logic [SRC_W-1:0] RST_SOURCE_WIDTH  = SRC_W'(640);
  localparam logic [SRC_W-1:0] RST_SOURCE_HEIGHT = SRC_W'(480);
  localparam logic [TGT_W-1:0] RST_TARGET_WIDTH  = TGT_W'(96);
  localparam logic [TGT_W-1:0] RST_TARGET_HEIGHT = TGT_W'(96);

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SRC_W-1:0] sw;
    logic [SRC_W-1:0] sh;
    logic [TGT_W-1:0] tw;
    logic [TGT_W-1:0] th;
  } sizes_t;

  typedef struct packed {
    logic hit;
    logic row_end;
    logic frame_end;
  } pick_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sample;
    logic              row_end;
    logic              frame_end;
  } result_t;

endpackage

// ----- rtl/core/yuyv_luma_nearest_downscaler_unit.sv -----
// Top level of the YUYV luma nearest-neighbor downscaler.
// Depends on ydn_pkg, ydn_cfg, ydn_track and ydn_oreg.
//
// channel   | direction | handshake                       | payload
// ----------+-----------+---------------------------------+-------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready   | tdata: stream_byte
// m_axis    | out       | m_axis_tvalid / m_axis_tready   | tdata: sample, tlast: row_end,
//           |           |                                 | tuser: frame_end
// cfg       | in        | cfg_we (no wait)                | cfg_index, cfg_data
//
// One input item per cycle while s_axis_tready is high; kept luma items go out registered.
// The skid stage behind the result register keeps s_axis_tready high while one result waits.
// rst (synchronous) and every size write restart the frame at the origin; no clearing pass.
// A stalled m_axis drops s_axis_tready only once both result slots are full.
module yuyv_luma_nearest_downscaler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ydn_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] stream_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ydn_pkg::BYTE_W-1:0]  m_axis_tdata,  // [7:0] sample
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser,  // [0] frame_end
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ydn_pkg::CFG_W-1:0]   cfg_data
);

  ydn_pkg::sizes_t  sizes;
  ydn_pkg::pick_t   pick;
  ydn_pkg::result_t push_data;
  ydn_pkg::result_t out_data;
  logic             restart;
  logic             take;
  logic             room;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  ydn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (ydn_pkg::cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .sizes     (sizes),
    .restart   (restart)
  );

  ydn_track u_track (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .restart (restart),
    .sizes   (sizes),
    .pick    (pick)
  );

  always_comb begin
    push_data.sample    = s_axis_tdata ^ ydn_pkg::LUMA_BIAS;
    push_data.row_end   = pick.row_end;
    push_data.frame_end = pick.frame_end;
  end

  ydn_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .push      (pick.hit),
    .push_data (push_data),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data.sample;
  assign m_axis_tlast = out_data.row_end;
  assign m_axis_tuser = out_data.frame_end;

endmodule

// ----- rtl/core/ydn_cfg.sv -----
// Size registers with clamping to the effective frame and output sizes.
// Depends on ydn_pkg.
module ydn_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  ydn_pkg::cfg_reg_t          cfg_index,
  input  logic [ydn_pkg::CFG_W-1:0]  cfg_data,
  output ydn_pkg::sizes_t            sizes,
  output logic                       restart
);

  logic [ydn_pkg::SRC_W-1:0] source_width;
  logic [ydn_pkg::SRC_W-1:0] source_height;
  logic [ydn_pkg::TGT_W-1:0] target_width;
  logic [ydn_pkg::TGT_W-1:0] target_height;

  logic [ydn_pkg::TGT_W-1:0] tw_lim;
  logic [ydn_pkg::TGT_W-1:0] th_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= ydn_pkg::RST_SOURCE_WIDTH;
      source_height <= ydn_pkg::RST_SOURCE_HEIGHT;
      target_width  <= ydn_pkg::RST_TARGET_WIDTH;
      target_height <= ydn_pkg::RST_TARGET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ydn_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[ydn_pkg::SRC_W-1:0];
        ydn_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[ydn_pkg::SRC_W-1:0];
        ydn_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data[ydn_pkg::TGT_W-1:0];
        ydn_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data[ydn_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_width == '0) sizes.sw = ydn_pkg::SRC_W'(1);
    else if (source_width > ydn_pkg::SRC_MAX) sizes.sw = ydn_pkg::SRC_MAX;
    else sizes.sw = source_width;

    if (source_height == '0) sizes.sh = ydn_pkg::SRC_W'(1);
    else if (source_height > ydn_pkg::SRC_MAX) sizes.sh = ydn_pkg::SRC_MAX;
    else sizes.sh = source_height;

    if (target_width == '0) tw_lim = ydn_pkg::TGT_W'(1);
    else if (target_width > ydn_pkg::TGT_MAX) tw_lim = ydn_pkg::TGT_MAX;
    else tw_lim = target_width;

    if (target_height == '0) th_lim = ydn_pkg::TGT_W'(1);
    else if (target_height > ydn_pkg::TGT_MAX) th_lim = ydn_pkg::TGT_MAX;
    else th_lim = target_height;

    if (ydn_pkg::SRC_W'(tw_lim) > sizes.sw) sizes.tw = sizes.sw[ydn_pkg::TGT_W-1:0];
    else sizes.tw = tw_lim;

    if (ydn_pkg::SRC_W'(th_lim) > sizes.sh) sizes.th = sizes.sh[ydn_pkg::TGT_W-1:0];
    else sizes.th = th_lim;
  end

  assign restart = cfg_we;

endmodule

// ----- rtl/core/ydn_track.sv -----
// Source and target position tracking with add-and-compare accumulators.
// Decides per luma item whether it is kept. Depends on ydn_pkg and the macros header.
`include "yuyv_luma_nearest_downscaler_unit_macros.svh"

module ydn_track (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic            restart,
  input  ydn_pkg::sizes_t sizes,
  output ydn_pkg::pick_t  pick
);

  logic                      phase;
  logic [ydn_pkg::POS_W-1:0] src_col;
  logic [ydn_pkg::POS_W-1:0] src_line;
  logic [ydn_pkg::DST_W-1:0] dst_col;
  logic [ydn_pkg::DST_W-1:0] dst_line;
  logic [ydn_pkg::ACC_W-1:0] col_want;
  logic [ydn_pkg::ACC_W-1:0] col_seen;
  logic [ydn_pkg::ACC_W-1:0] line_want;
  logic [ydn_pkg::ACC_W-1:0] line_seen;

  logic                      phase_next;
  logic [ydn_pkg::POS_W-1:0] src_col_next;
  logic [ydn_pkg::POS_W-1:0] src_line_next;
  logic [ydn_pkg::DST_W-1:0] dst_col_next;
  logic [ydn_pkg::DST_W-1:0] dst_line_next;
  logic [ydn_pkg::ACC_W-1:0] col_want_next;
  logic [ydn_pkg::ACC_W-1:0] col_seen_next;
  logic [ydn_pkg::ACC_W-1:0] line_want_next;
  logic [ydn_pkg::ACC_W-1:0] line_seen_next;

  logic                      col_hit;
  logic                      line_hit;
  logic [ydn_pkg::SRC_W-1:0] col_inc;
  logic [ydn_pkg::SRC_W-1:0] line_inc;

  always_comb begin
    col_hit = (dst_col < sizes.tw) && (col_seen <= col_want) &&
              (col_want < col_seen + ydn_pkg::ACC_W'(sizes.tw));
    line_hit = (dst_line < sizes.th) && (line_seen <= line_want) &&
               (line_want < line_seen + ydn_pkg::ACC_W'(sizes.th));

    pick.hit       = take && !phase && col_hit && line_hit;
    pick.row_end   = (dst_col + ydn_pkg::DST_W'(1)) == sizes.tw;
    pick.frame_end = pick.row_end && ((dst_line + ydn_pkg::DST_W'(1)) == sizes.th);

    col_inc  = ydn_pkg::SRC_W'(src_col) + ydn_pkg::SRC_W'(1);
    line_inc = ydn_pkg::SRC_W'(src_line) + ydn_pkg::SRC_W'(1);

    phase_next     = phase;
    src_col_next   = src_col;
    src_line_next  = src_line;
    dst_col_next   = dst_col;
    dst_line_next  = dst_line;
    col_want_next  = col_want;
    col_seen_next  = col_seen;
    line_want_next = line_want;
    line_seen_next = line_seen;

    if (take) begin
      if (!phase) begin
        phase_next = 1'b1;
      end else begin
        phase_next = 1'b0;
        if (col_hit) begin
          dst_col_next  = dst_col + ydn_pkg::DST_W'(1);
          col_want_next = col_want + ydn_pkg::ACC_W'(sizes.sw);
        end
        if (col_inc >= sizes.sw) begin
          src_col_next  = '0;
          col_seen_next = '0;
          dst_col_next  = '0;
          col_want_next = '0;
          if (line_hit) begin
            dst_line_next  = dst_line + ydn_pkg::DST_W'(1);
            line_want_next = line_want + ydn_pkg::ACC_W'(sizes.sh);
          end
          if (line_inc >= sizes.sh) begin
            src_line_next  = '0;
            line_seen_next = '0;
            dst_line_next  = '0;
            line_want_next = '0;
          end else begin
            src_line_next  = line_inc[ydn_pkg::POS_W-1:0];
            line_seen_next = line_seen + ydn_pkg::ACC_W'(sizes.th);
          end
        end else begin
          src_col_next  = col_inc[ydn_pkg::POS_W-1:0];
          col_seen_next = col_seen + ydn_pkg::ACC_W'(sizes.tw);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase     <= 1'b0;
      src_col   <= '0;
      src_line  <= '0;
      dst_col   <= '0;
      dst_line  <= '0;
      col_want  <= '0;
      col_seen  <= '0;
      line_want <= '0;
      line_seen <= '0;
    end else begin
      phase     <= phase_next;
      src_col   <= src_col_next;
      src_line  <= src_line_next;
      dst_col   <= dst_col_next;
      dst_line  <= dst_line_next;
      col_want  <= col_want_next;
      col_seen  <= col_seen_next;
      line_want <= line_want_next;
      line_seen <= line_seen_next;
    end
  end

  `YDN_ASSERT_IMP(a_dst_col_bound, clk, rst, 1'b1, dst_col <= sizes.tw)
  `YDN_ASSERT_IMP(a_dst_line_bound, clk, rst, 1'b1, dst_line <= sizes.th)
  `YDN_ASSERT_NXT(a_luma_then_chroma, clk, rst, take && !phase && !restart, phase)

endmodule

// ----- rtl/core/ydn_oreg.sv -----
// Result register with a skid stage so input stays open while a result waits.
// Depends on ydn_pkg and the macros header.
`include "yuyv_luma_nearest_downscaler_unit_macros.svh"

module ydn_oreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ydn_pkg::result_t  push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ydn_pkg::result_t  out_data
);

  logic             main_valid;
  logic             skid_valid;
  ydn_pkg::result_t main_data;
  ydn_pkg::result_t skid_data;
  logic             pop;

  assign pop       = main_valid && out_ready;
  assign room      = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `YDN_ASSERT_IMP(a_skid_needs_main, clk, rst, skid_valid, main_valid)
  `YDN_ASSERT_NXT(a_stall_fills_skid, clk, rst, main_valid && !out_ready && push, skid_valid)
  `YDN_ASSERT_NXT(a_skid_moves_up, clk, rst, skid_valid && out_ready, main_valid && !skid_valid)

endmodule
